// ===== design/xyppm_pkg.sv =====
// ----------------------------------------------------------------------------
// xyppm_pkg
// Shared constants and pipeline types for the x/y point plot mapper.
// ----------------------------------------------------------------------------
package xyppm_pkg;

    // plot geometry
    localparam int PLOT_SPAN = 120;
    localparam int ORIGIN_X  = 4;
    localparam int ORIGIN_Y  = 36;

    // field widths
    localparam int COORD_W    = 32;
    localparam int QUOT_W     = $clog2(PLOT_SPAN + 1);
    localparam int NUM_W      = COORD_W + QUOT_W;
    localparam int PIX_X_W    = 7;
    localparam int PIX_Y_W    = 8;
    localparam int CFG_ADDR_W = 2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_X = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_Y = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_Y = 2'd3;

    // one axis in the restoring divider
    typedef struct packed {
        logic [NUM_W-1:0]   rem;
        logic [COORD_W-1:0] span;
        logic [QUOT_W-1:0]  quot;
        logic               zero;
    } axis_div_t;

    typedef struct packed {
        axis_div_t x;
        axis_div_t y;
        logic      fin;
    } point_div_t;

endpackage

// ===== design/xy_point_plot_mapper.sv =====
// ----------------------------------------------------------------------------
// xy_point_plot_mapper
// Maps signed data points into a 120x120 plot area and draws each as a 2x2 dot.
// ----------------------------------------------------------------------------
// The block takes one point (x, y) per request and, if the point lies inside
// the configured window (bounds included), emits four pixel requests forming a
// 2x2 dot: (col,row), (col+1,row), (col,row+1), (col+1,row+1), where
// col = 4 + floor((x-min_x)*120/(max_x-min_x)) and
// row = 156 - floor((y-min_y)*120/(max_y-min_y)). A zero span gives a scaled
// value of 0; points outside the window (or any point when min > max) are
// dropped without output. A new point is accepted every cycle while the
// pipeline has room; in-window points are paced by the four-beat dot
// serializer at the output, which takes the next point as the last beat of
// the current dot is sent. From input to the first pixel a point passes the
// window test and differences, the multiply by 120, a 7-stage restoring
// divider (one quotient bit per stage, both axes in parallel) and the
// serializer. Window registers may only be written while the block is idle.
// ----------------------------------------------------------------------------
module xy_point_plot_mapper (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [xyppm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [xyppm_pkg::COORD_W-1:0]       cfg_wdata,
    // point input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,   // point_x[31:0], point_y[63:32]
    input  logic                                s_tlast,   // final_point
    // pixel output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // pixel_x[6:0], pixel_y[14:7], 0
    output logic                                m_tlast,   // last_pixel
    output logic                                m_tuser    // set_done
);
    import xyppm_pkg::*;

    // ------------------------------------------------------------------------
    // window registers
    // ------------------------------------------------------------------------
    logic signed [COORD_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= COORD_W'(0);
            max_x_reg <= COORD_W'(100);
            min_y_reg <= COORD_W'(0);
            max_y_reg <= COORD_W'(100);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MIN_X: min_x_reg <= cfg_wdata;
                REG_MAX_X: max_x_reg <= cfg_wdata;
                REG_MIN_Y: min_y_reg <= cfg_wdata;
                REG_MAX_Y: max_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // flow control: a stage loads when empty or when its content moves on
    // ------------------------------------------------------------------------
    logic                v0_reg;
    logic [QUOT_W:0]     vp_reg;     // valid of multiply stage and divider stages
    logic                ser_v_reg;
    logic [1:0]          beat_reg;
    logic                ser_free;
    logic                ld0;
    logic [QUOT_W:0]     ldp;

    assign ser_free = !ser_v_reg || (beat_reg == 2'd3 && m_tready);

    always_comb begin
        ldp[QUOT_W] = !vp_reg[QUOT_W] || ser_free;
        for (int k = QUOT_W - 1; k >= 0; k--)
            ldp[k] = !vp_reg[k] || ldp[k+1];
    end

    assign ld0      = !v0_reg || ldp[0];
    assign s_tready = ld0;

    // ------------------------------------------------------------------------
    // stage 0: window test and differences
    // ------------------------------------------------------------------------
    logic signed [COORD_W-1:0] px, py;
    logic                      in_window;
    logic [COORD_W-1:0]        diff_x_reg, span_x_reg, diff_y_reg, span_y_reg;
    logic                      fin0_reg;
    logic                      v0_next;

    assign px = s_tdata[COORD_W-1:0];
    assign py = s_tdata[2*COORD_W-1:COORD_W];

    assign in_window = (px >= min_x_reg) && (px <= max_x_reg) &&
                       (py >= min_y_reg) && (py <= max_y_reg);
    assign v0_next   = s_tvalid && in_window;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v0_reg <= 1'b0;
        else if (ld0)
            v0_reg <= v0_next;
    end

    // inside the window both differences fit 32 bits unsigned
    always_ff @(posedge aclk) begin
        if (ld0) begin
            diff_x_reg <= COORD_W'(px - min_x_reg);
            span_x_reg <= COORD_W'(max_x_reg - min_x_reg);
            diff_y_reg <= COORD_W'(py - min_y_reg);
            span_y_reg <= COORD_W'(max_y_reg - min_y_reg);
            fin0_reg   <= s_tlast;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: numerator = diff * PLOT_SPAN; stages 2..: restoring divider
    // ------------------------------------------------------------------------
    point_div_t pd_reg  [0:QUOT_W];
    point_div_t pd_next [0:QUOT_W];

    function automatic axis_div_t div_step(axis_div_t a, int b);
        axis_div_t          r;
        logic [NUM_W-1:0]   sh;
        r  = a;
        sh = NUM_W'(a.span) << b;
        if (!a.zero && a.rem >= sh) begin
            r.rem     = a.rem - sh;
            r.quot[b] = 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        pd_next[0].x.rem  = NUM_W'(diff_x_reg) * NUM_W'(PLOT_SPAN);
        pd_next[0].x.span = span_x_reg;
        pd_next[0].x.quot = '0;
        pd_next[0].x.zero = (span_x_reg == '0);
        pd_next[0].y.rem  = NUM_W'(diff_y_reg) * NUM_W'(PLOT_SPAN);
        pd_next[0].y.span = span_y_reg;
        pd_next[0].y.quot = '0;
        pd_next[0].y.zero = (span_y_reg == '0);
        pd_next[0].fin    = fin0_reg;
        for (int k = 1; k <= QUOT_W; k++) begin
            pd_next[k].x   = div_step(pd_reg[k-1].x, QUOT_W - k);
            pd_next[k].y   = div_step(pd_reg[k-1].y, QUOT_W - k);
            pd_next[k].fin = pd_reg[k-1].fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= '0;
        end else begin
            if (ldp[0])
                vp_reg[0] <= v0_reg;
            for (int k = 1; k <= QUOT_W; k++) begin
                if (ldp[k])
                    vp_reg[k] <= vp_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k <= QUOT_W; k++) begin
            if (ldp[k])
                pd_reg[k] <= pd_next[k];
        end
    end

    // ------------------------------------------------------------------------
    // dot serializer: four pixel beats per point
    // ------------------------------------------------------------------------
    logic               ser_take;
    logic [PIX_X_W-1:0] col_reg, col_next;
    logic [PIX_Y_W-1:0] row_reg, row_next;
    logic               fin_reg;

    assign ser_take = vp_reg[QUOT_W] && ser_free;
    assign col_next = PIX_X_W'(ORIGIN_X) + pd_reg[QUOT_W].x.quot;
    assign row_next = PIX_Y_W'(ORIGIN_Y + PLOT_SPAN) - PIX_Y_W'(pd_reg[QUOT_W].y.quot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_v_reg <= 1'b0;
            beat_reg  <= 2'd0;
        end else if (ser_take) begin
            ser_v_reg <= 1'b1;
            beat_reg  <= 2'd0;
        end else if (ser_v_reg && m_tready) begin
            if (beat_reg == 2'd3)
                ser_v_reg <= 1'b0;
            beat_reg <= beat_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ser_take) begin
            col_reg <= col_next;
            row_reg <= row_next;
            fin_reg <= pd_reg[QUOT_W].fin;
        end
    end

    assign m_tvalid = ser_v_reg;
    assign m_tdata  = {1'b0,
                       row_reg + PIX_Y_W'(beat_reg[1]),
                       col_reg + PIX_X_W'(beat_reg[0])};
    assign m_tlast  = (beat_reg == 2'd3);
    assign m_tuser  = (beat_reg == 2'd3) && fin_reg;

endmodule
